[sv/perspective_coordinate_map_defines.svh]
// assertion macros for the perspective coordinate map
// used by the top level only; expects a clk and rst in scope
`ifndef PERSPECTIVE_COORDINATE_MAP_DEFINES_SVH
`define PERSPECTIVE_COORDINATE_MAP_DEFINES_SVH

// same-cycle implication, off during reset
`define PCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pcm_pkg.sv]
// shared types and constants for the perspective coordinate map
// no dependencies
package pcm_pkg;

  localparam int COORD_BITS = 12;
  localparam int COEF_W     = 32;
  localparam int IN_W       = 12;
  localparam int Q_W        = 24;
  localparam int PROD_W     = COEF_W + COORD_BITS + 1;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DIV_W      = NUM_W + Q_W + 1;
  localparam int N_COEF     = 8;
  localparam int IDX_W      = 4;

  localparam logic signed [COEF_W-1:0] Q_ONE = 32'sd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_A = 4'd0, REG_B = 4'd1, REG_C = 4'd2, REG_D = 4'd3,
    REG_E = 4'd4, REG_F = 4'd5, REG_G = 4'd6, REG_H = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [IN_W-1:0] out_col;
    logic [IN_W-1:0] out_row;
  } pix_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] src_col;
    logic signed [Q_W-1:0] src_row;
    logic                  invalid;
  } pix_out_t;

  typedef logic [N_COEF-1:0][COEF_W-1:0] coef_bank_t;

  // per-item flags that ride along with the divider chain
  typedef struct packed {
    logic zero_den;
    logic nx_neg;
    logic nx_zero;
    logic ny_neg;
    logic ny_zero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

endpackage

[sv/pcm_front.sv]
// front end: products, sums, magnitudes and divider setup
// depends on pcm_pkg
module pcm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  pcm_pkg::pix_in_t   pix,
  input  pcm_pkg::coef_bank_t coef,
  output logic               vld_out,
  output pcm_pkg::side_t     side_out,
  output logic [pcm_pkg::DIV_W-1:0] rx_out,
  output logic [pcm_pkg::DIV_W-1:0] ry_out,
  output logic [pcm_pkg::DIV_W-1:0] ds_out
);
  import pcm_pkg::*;

  logic [COORD_BITS-1:0] x0, y0;
  logic                  v0, v1, v2, v3;
  logic signed [PROD_W-1:0] p_ax, p_by, p_dx, p_ey, p_gx, p_hy;
  logic signed [COEF_W-1:0] c_c, c_f;
  logic signed [NUM_W-1:0]  num_x, num_y, den;
  logic [NUM_W-1:0]         mag_x, mag_y, mag_d;
  side_t                    side3;

  logic signed [COORD_BITS:0] xs, ys;
  logic [DIV_W-1:0] nn_x, nn_y, d2;

  assign xs = $signed({1'b0, x0});
  assign ys = $signed({1'b0, y0});

  assign d2   = DIV_W'(mag_d) << 1;
  assign nn_x = (DIV_W'(mag_x) << 9) + DIV_W'(mag_d);
  assign nn_y = (DIV_W'(mag_y) << 9) + DIV_W'(mag_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      v0 <= vld_in;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      vld_out <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= pix.out_col[COORD_BITS-1:0];
      y0 <= pix.out_row[COORD_BITS-1:0];

      p_ax <= PROD_W'($signed(coef[REG_A])) * PROD_W'(xs);
      p_by <= PROD_W'($signed(coef[REG_B])) * PROD_W'(ys);
      p_dx <= PROD_W'($signed(coef[REG_D])) * PROD_W'(xs);
      p_ey <= PROD_W'($signed(coef[REG_E])) * PROD_W'(ys);
      p_gx <= PROD_W'($signed(coef[REG_G])) * PROD_W'(xs);
      p_hy <= PROD_W'($signed(coef[REG_H])) * PROD_W'(ys);
      c_c  <= $signed(coef[REG_C]);
      c_f  <= $signed(coef[REG_F]);

      num_x <= NUM_W'(p_ax) + NUM_W'(p_by) + NUM_W'(c_c);
      num_y <= NUM_W'(p_dx) + NUM_W'(p_ey) + NUM_W'(c_f);
      den   <= NUM_W'(p_gx) + NUM_W'(p_hy) + NUM_W'(Q_ONE);

      mag_x <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      mag_y <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      mag_d <= den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
      side3.zero_den <= (den == '0);
      side3.nx_neg   <= num_x[NUM_W-1];
      side3.nx_zero  <= (num_x == '0);
      side3.ny_neg   <= num_y[NUM_W-1];
      side3.ny_zero  <= (num_y == '0);
      side3.neg_x    <= num_x[NUM_W-1] ^ den[NUM_W-1];
      side3.neg_y    <= num_y[NUM_W-1] ^ den[NUM_W-1];
      side3.ovf_x    <= 1'b0;
      side3.ovf_y    <= 1'b0;

      // quotient needs more than Q_W bits: saturate later
      rx_out   <= nn_x;
      ry_out   <= nn_y;
      ds_out   <= d2 << (Q_W - 1);
      side_out <= '{zero_den: side3.zero_den, nx_neg: side3.nx_neg,
                    nx_zero: side3.nx_zero, ny_neg: side3.ny_neg,
                    ny_zero: side3.ny_zero, neg_x: side3.neg_x,
                    neg_y: side3.neg_y,
                    ovf_x: (nn_x >= (d2 << Q_W)),
                    ovf_y: (nn_y >= (d2 << Q_W))};
    end
  end

endmodule

[sv/pcm_div_cell.sv]
// one restoring-division cell: one quotient bit for each axis
// depends on pcm_pkg
module pcm_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vld_in,
  input  pcm_pkg::side_t          side_in,
  input  logic [pcm_pkg::DIV_W-1:0] rx_in,
  input  logic [pcm_pkg::DIV_W-1:0] ry_in,
  input  logic [pcm_pkg::DIV_W-1:0] ds_in,
  input  logic [pcm_pkg::Q_W-1:0]   qx_in,
  input  logic [pcm_pkg::Q_W-1:0]   qy_in,
  output logic                    vld_out,
  output pcm_pkg::side_t          side_out,
  output logic [pcm_pkg::DIV_W-1:0] rx_out,
  output logic [pcm_pkg::DIV_W-1:0] ry_out,
  output logic [pcm_pkg::DIV_W-1:0] ds_out,
  output logic [pcm_pkg::Q_W-1:0]   qx_out,
  output logic [pcm_pkg::Q_W-1:0]   qy_out
);
  import pcm_pkg::*;

  logic ge_x, ge_y;

  assign ge_x = (rx_in >= ds_in);
  assign ge_y = (ry_in >= ds_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      rx_out   <= ge_x ? rx_in - ds_in : rx_in;
      ry_out   <= ge_y ? ry_in - ds_in : ry_in;
      ds_out   <= ds_in >> 1;
      qx_out   <= {qx_in[Q_W-2:0], ge_x};
      qy_out   <= {qy_in[Q_W-2:0], ge_y};
    end
  end

endmodule

[sv/perspective_coordinate_map.sv]
// top level of the perspective coordinate map
// depends on pcm_pkg, pcm_front, pcm_div_cell and the assertion macro header
//
// Maps an output pixel (out_col, out_row) through an inverse homography held
// in eight Q16.16 coefficient registers and returns the source position in
// signed Q16.8, rounded to nearest with ties away from zero and saturated.
// invalid is set when the denominator is zero or a coordinate saturated.
// Input beats arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data, one result per input beat, in order.
// Coefficients are written through cfg_wen/cfg_addr/cfg_wdata; the user must
// write them only while idle, which the block does not enforce. Indexes of 8
// and above are ignored. The pipeline has five front-end stages (input,
// products, sums, magnitudes, divider setup), a chain of 24 division cells
// that each settle one quotient bit, and the output register.
// Throughput is one beat per cycle unless stalled; every stage is a register.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing in flight is lost.
// Reset clears all valid bits and loads the identity mapping.
module perspective_coordinate_map (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcm_pkg::pix_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pcm_pkg::pix_out_t         out_data,
  input  logic                      cfg_wen,
  input  logic [pcm_pkg::IDX_W-1:0] cfg_addr,
  input  logic [pcm_pkg::COEF_W-1:0] cfg_wdata
);
  import pcm_pkg::*;
  `include "perspective_coordinate_map_defines.svh"

  localparam logic [Q_W-1:0] OUT_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] OUT_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // identity mapping, register A in the low word
  localparam coef_bank_t COEF_RST = {COEF_W'(0), COEF_W'(0), COEF_W'(0), Q_ONE,
                                     COEF_W'(0), COEF_W'(0), COEF_W'(0), Q_ONE};

  typedef struct packed {
    logic [Q_W-1:0] v;
    logic           f;
  } axis_t;

  coef_bank_t coef;
  logic       en;

  logic  vld   [0:Q_W];
  side_t side  [0:Q_W];
  logic [DIV_W-1:0] rx [0:Q_W];
  logic [DIV_W-1:0] ry [0:Q_W];
  logic [DIV_W-1:0] ds [0:Q_W];
  logic [Q_W-1:0]   qx [0:Q_W];
  logic [Q_W-1:0]   qy [0:Q_W];

  axis_t ax, ay;
  logic  out_zero;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RST;
    end else if (cfg_wen && (cfg_addr < IDX_W'(N_COEF))) begin
      coef[cfg_addr[2:0]] <= cfg_wdata;
    end
  end

  pcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (in_valid),
    .pix      (in_data),
    .coef     (coef),
    .vld_out  (vld[0]),
    .side_out (side[0]),
    .rx_out   (rx[0]),
    .ry_out   (ry[0]),
    .ds_out   (ds[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    pcm_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (vld[k]),
      .side_in  (side[k]),
      .rx_in    (rx[k]),
      .ry_in    (ry[k]),
      .ds_in    (ds[k]),
      .qx_in    (qx[k]),
      .qy_in    (qy[k]),
      .vld_out  (vld[k+1]),
      .side_out (side[k+1]),
      .rx_out   (rx[k+1]),
      .ry_out   (ry[k+1]),
      .ds_out   (ds[k+1]),
      .qx_out   (qx[k+1]),
      .qy_out   (qy[k+1])
    );
  end

  function automatic axis_t axis_out(input logic [Q_W-1:0] q, input logic zero,
                                     input logic nneg, input logic nzero,
                                     input logic neg, input logic ovf);
    axis_t r;
    r.f = 1'b0;
    r.v = q;
    if (zero) begin
      r.f = 1'b1;
      r.v = nzero ? '0 : (nneg ? OUT_MIN : OUT_MAX);
    end else if (neg) begin
      // magnitude of exactly 2^(Q_W-1) still fits
      if (ovf || (q > OUT_MIN)) begin
        r.f = 1'b1;
        r.v = OUT_MIN;
      end else begin
        r.v = Q_W'(-q);
      end
    end else if (ovf || (q > OUT_MAX)) begin
      r.f = 1'b1;
      r.v = OUT_MAX;
    end
    return r;
  endfunction

  assign ax = axis_out(qx[Q_W], side[Q_W].zero_den, side[Q_W].nx_neg,
                       side[Q_W].nx_zero, side[Q_W].neg_x, side[Q_W].ovf_x);
  assign ay = axis_out(qy[Q_W], side[Q_W].zero_den, side[Q_W].ny_neg,
                       side[Q_W].ny_zero, side[Q_W].neg_y, side[Q_W].ovf_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.src_col <= $signed(ax.v);
      out_data.src_row <= $signed(ay.v);
      out_data.invalid <= ax.f | ay.f;
      out_zero         <= side[Q_W].zero_den;
    end
  end

  `PCM_ASSERT_IMP(a_zero_den_ovf, vld[0] && side[0].zero_den, side[0].ovf_x && side[0].ovf_y, "zero denominator not caught by overflow check")
  `PCM_ASSERT_IMP(a_zero_den_flag, out_valid && out_zero, out_data.invalid, "zero denominator result not flagged")
  `PCM_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, vld[Q_W] == $past(vld[Q_W]), "chain moved during stall")
  `PCM_ASSERT_IMP(a_ready_rule, out_valid && !out_ready, !in_ready, "input taken while output stalled")

endmodule

[tb/tb_top.sv]
// testbench for the perspective coordinate map: random and directed beats,
// self-checking against an inline fixed-point mapping; depends on pcm_pkg
`timescale 1ns / 100ps
module tb_top;
  import pcm_pkg::*;

  localparam int LATENCY = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  logic cfg_wen = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;
  // input beat taken at the last rising edge
  logic in_fire = 1'b0;

  perspective_coordinate_map dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [COEF_W-1:0] coef [N_COEF];
  pix_in_t pixel_q [$];
  pix_out_t mapped_q [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  // rounded, saturated quotient in Q16.8
  function automatic logic signed [Q_W-1:0] map_axis(input longint num, input longint den,
                                                     inout bit flag);
    logic [127:0] n, d, q;
    bit neg;
    if (den == 0) begin
      flag = 1;
      if (num > 0) return 24'sh7FFFFF;
      if (num < 0) return 24'sh800000;
      return '0;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n * 512 + d) / (2 * d);
    if (neg) begin
      if (q > 128'd8388608) begin
        flag = 1;
        return 24'sh800000;
      end
      return -q[Q_W-1:0];
    end
    if (q > 128'd8388607) begin
      flag = 1;
      return 24'sh7FFFFF;
    end
    return q[Q_W-1:0];
  endfunction

  function automatic pix_out_t warp_pixel(input pix_in_t p);
    longint x, y, nx, ny, den;
    bit flag;
    pix_out_t r;
    flag = 0;
    x = longint'(p.out_col & ((1 << COORD_BITS) - 1));
    y = longint'(p.out_row & ((1 << COORD_BITS) - 1));
    nx = longint'(coef[REG_A]) * x + longint'(coef[REG_B]) * y + longint'(coef[REG_C]);
    ny = longint'(coef[REG_D]) * x + longint'(coef[REG_E]) * y + longint'(coef[REG_F]);
    den = longint'(coef[REG_G]) * x + longint'(coef[REG_H]) * y + 65536;
    r.src_col = map_axis(nx, den, flag);
    r.src_row = map_axis(ny, den, flag);
    r.invalid = flag;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_fire) begin
        // hold beat
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst) begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) mapped_q.insert(mapped_q.size(), warp_pixel(in_data));
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = mapped_q.pop_front();
          if (out_data.src_col !== want.src_col) begin
            $error("src_col expected %0d got %0d", want.src_col, out_data.src_col);
            errors++;
          end
          if (out_data.src_row !== want.src_row) begin
            $error("src_row expected %0d got %0d", want.src_row, out_data.src_row);
            errors++;
          end
          if (out_data.invalid !== want.invalid) begin
            $error("invalid expected %0d got %0d", want.invalid, out_data.invalid);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid || mapped_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx < N_COEF) coef[idx[2:0]] = val;
  endtask

  task automatic add_pixel(input int col, input int row);
    pix_in_t p;
    p.out_col = IN_W'(col);
    p.out_row = IN_W'(row);
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(1 << 18) - (1 << 17);
      3: return $urandom_range(1 << 12) - (1 << 11);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int n;
    coef[REG_A] = Q_ONE; coef[REG_B] = 0; coef[REG_C] = 0; coef[REG_D] = 0;
    coef[REG_E] = Q_ONE; coef[REG_F] = 0; coef[REG_G] = 0; coef[REG_H] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // identity mapping, field extremes
    add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(4095, 0); add_pixel(0, 4095);
    add_pixel(2730, 1365);
    wait_drained();
    // zero denominator at column 1: positive and negative numerators
    write_coef(REG_A, 32'h00010000); write_coef(REG_B, 0);
    write_coef(REG_C, 32'h00000100); write_coef(REG_D, 0); write_coef(REG_E, 0);
    write_coef(REG_F, 32'hFFFFFF00); write_coef(REG_G, 32'hFFFF0000);
    write_coef(REG_H, 0);
    write_coef(4'd8, 32'h12345678); write_coef(4'd15, 32'hFFFFFFFF);
    add_pixel(1, 7); add_pixel(0, 0); add_pixel(2, 3); add_pixel(4095, 1);
    wait_drained();
    // positive overflow on both axes, exact minimum, rounding ties
    write_coef(REG_A, 32'h7FFFFFFF); write_coef(REG_C, 32'h80000000);
    write_coef(REG_D, 32'h80000000); write_coef(REG_E, 32'h7FFFFFFF);
    write_coef(REG_F, 32'h00000080); write_coef(REG_G, 0); write_coef(REG_H, 0);
    add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(1, 0); add_pixel(0, 1);
    wait_drained();
    write_coef(REG_A, 32'hFFFFFF80); write_coef(REG_C, 0); write_coef(REG_D, 0);
    write_coef(REG_E, 0); write_coef(REG_F, 32'h80000000);
    write_coef(REG_G, 32'h00000001); write_coef(REG_H, 32'h80000000);
    add_pixel(1, 0); add_pixel(3, 0); add_pixel(0, 1); add_pixel(5, 4095);
    wait_drained();
    // random phases with different idling and coefficient sets
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 76; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 76; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      for (int i = 0; i < N_COEF; i++) write_coef(IDX_W'(i), rand_coef());
      if (ph == 0) begin
        write_coef(REG_G, 0); write_coef(REG_H, 0);
      end
      n = 0;
      while (n < 118) begin
        add_pixel($urandom_range(4095), $urandom_range(4095));
        n++;
        if (n == 60 && ph == 2) begin
          while (pixel_q.size() > 0 || in_valid || mapped_q.size() > 0) @(posedge clk);
        end
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
